[sv/polynomial_add_multiply_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the polynomial add / multiply unit.
// Each macro expects clk and rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_ADD_MULTIPLY_UNIT_ASSERT_SVH
`define POLYNOMIAL_ADD_MULTIPLY_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define PAM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define PAM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pam_pkg.sv]
// ---------------------------------------------------------------------------
// pam_pkg
// Sizes, command codes, control word layout and microcode ROM of the
// polynomial add / multiply unit.
// ---------------------------------------------------------------------------
`default_nettype none

package pam_pkg;

    localparam int MAX_TERMS = 32;
    localparam int COEF_BITS = 16;

    localparam int CMD_W     = 2;
    localparam int IN_COEF_W = 16;
    localparam int RES_W     = 37;
    localparam int EXP_W     = 6;

    localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int PROD_W = 2 * COEF_BITS;
    localparam int UPC_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_COMPUTE       = 2'd2,
        CMD_CLEAR         = 2'd3
    } cmd_t;

    // A step waits on its hold condition before its operations fire.
    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_IN   = 2'd1,
        HOLD_PIPE = 2'd2,
        HOLD_OUT  = 2'd3
    } hold_t;

    typedef enum logic [2:0] {
        J_NEVER       = 3'd0,
        J_ALWAYS      = 3'd1,
        J_NOT_COMPUTE = 3'd2,
        J_EMPTY       = 3'd3,
        J_MORE_J      = 3'd4,
        J_LAST_TERM   = 3'd5
    } jcond_t;

    typedef struct packed {
        logic accept;
        logic init_i;
        logic init_term;
        logic issue;
        logic emit_acc;
        logic emit_zero;
    } ops_t;

    typedef struct packed {
        hold_t              hold;
        jcond_t             jcond;
        logic [UPC_W-1:0]   target;
        ops_t               ops;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic not_compute;
        logic empty;
        logic more_j;
        logic last_term;
        logic pipe_empty;
        logic out_free;
    } sts_t;

    localparam logic [UPC_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] STEP_START = 3'd1;
    localparam logic [UPC_W-1:0] STEP_TERM  = 3'd2;
    localparam logic [UPC_W-1:0] STEP_ISSUE = 3'd3;
    localparam logic [UPC_W-1:0] STEP_DRAIN = 3'd4;
    localparam logic [UPC_W-1:0] STEP_EMIT  = 3'd5;
    localparam logic [UPC_W-1:0] STEP_NEXT  = 3'd6;
    localparam logic [UPC_W-1:0] STEP_EMPTY = 3'd7;

    localparam ops_t OPS_NONE      = '{default: 1'b0};
    localparam ops_t OPS_ACCEPT    = '{accept: 1'b1, default: 1'b0};
    localparam ops_t OPS_INIT_I    = '{init_i: 1'b1, default: 1'b0};
    localparam ops_t OPS_INIT_TERM = '{init_term: 1'b1, default: 1'b0};
    localparam ops_t OPS_ISSUE     = '{issue: 1'b1, default: 1'b0};
    localparam ops_t OPS_EMIT_ACC  = '{emit_acc: 1'b1, default: 1'b0};
    localparam ops_t OPS_EMIT_ZERO = '{emit_zero: 1'b1, default: 1'b0};

    // Microcode ROM: one control word per step.
    function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
        uword_t w;
        case (upc)
            STEP_IDLE:  w = '{hold: HOLD_IN,   jcond: J_NOT_COMPUTE, target: STEP_IDLE,
                              ops: OPS_ACCEPT};
            STEP_START: w = '{hold: HOLD_NONE, jcond: J_EMPTY,       target: STEP_EMPTY,
                              ops: OPS_INIT_I};
            STEP_TERM:  w = '{hold: HOLD_NONE, jcond: J_NEVER,       target: STEP_IDLE,
                              ops: OPS_INIT_TERM};
            STEP_ISSUE: w = '{hold: HOLD_NONE, jcond: J_MORE_J,      target: STEP_ISSUE,
                              ops: OPS_ISSUE};
            STEP_DRAIN: w = '{hold: HOLD_PIPE, jcond: J_NEVER,       target: STEP_IDLE,
                              ops: OPS_NONE};
            STEP_EMIT:  w = '{hold: HOLD_OUT,  jcond: J_LAST_TERM,   target: STEP_IDLE,
                              ops: OPS_EMIT_ACC};
            STEP_NEXT:  w = '{hold: HOLD_NONE, jcond: J_ALWAYS,      target: STEP_ISSUE,
                              ops: OPS_INIT_TERM};
            STEP_EMPTY: w = '{hold: HOLD_OUT,  jcond: J_ALWAYS,      target: STEP_IDLE,
                              ops: OPS_EMIT_ZERO};
            default:    w = '{hold: HOLD_IN,   jcond: J_NOT_COMPUTE, target: STEP_IDLE,
                              ops: OPS_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/pam_if.sv]
// ---------------------------------------------------------------------------
// pam_if
// Valid/ready channels of the polynomial add / multiply unit: the command
// word going in and the result term word coming out.
// ---------------------------------------------------------------------------
`default_nettype none

interface pam_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [pam_pkg::CMD_W-1:0]              cmd;
    logic signed [pam_pkg::IN_COEF_W-1:0]   coefficient;

    modport source (output valid, output cmd, output coefficient, input ready);
    modport sink   (input valid, input cmd, input coefficient, output ready);
endinterface

interface pam_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pam_pkg::RES_W-1:0]   result_coefficient;
    logic [pam_pkg::EXP_W-1:0]          exponent;
    logic                               last;

    modport source (output valid, output result_coefficient, output exponent,
                    output last, input ready);
    modport sink   (input valid, input result_coefficient, input exponent,
                    input last, output ready);
endinterface

`default_nettype wire

[sv/pam_ram.sv]
// ---------------------------------------------------------------------------
// pam_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/pam_seq.sv]
// ---------------------------------------------------------------------------
// pam_seq
// Microcode sequencer: step counter, ROM lookup, hold and branch logic.
// ---------------------------------------------------------------------------
`default_nettype none

module pam_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pam_pkg::sts_t sts,
    output      pam_pkg::ops_t ops,
    output      logic          ready
);
    import pam_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           word;
    logic             go;
    logic             jump;

    assign word  = ucode(upc_reg);
    assign ready = word.ops.accept;

    always_comb
    begin
        case (word.hold)
            HOLD_NONE: go = 1'b1;
            HOLD_IN:   go = sts.in_valid;
            HOLD_PIPE: go = sts.pipe_empty;
            HOLD_OUT:  go = sts.out_free;
            default:   go = 1'b0;
        endcase

        case (word.jcond)
            J_NEVER:       jump = 1'b0;
            J_ALWAYS:      jump = 1'b1;
            J_NOT_COMPUTE: jump = sts.not_compute;
            J_EMPTY:       jump = sts.empty;
            J_MORE_J:      jump = sts.more_j;
            J_LAST_TERM:   jump = sts.last_term;
            default:       jump = 1'b0;
        endcase

        if (!go)
        begin
            upc_next = upc_reg;
        end
        else if (jump)
        begin
            upc_next = word.target;
        end
        else
        begin
            upc_next = upc_reg + UPC_W'(1);
        end

        ops = go ? word.ops : OPS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

[sv/pam_datapath.sv]
// ---------------------------------------------------------------------------
// pam_datapath
// Coefficient stores, term index counters, multiply-accumulate pipeline and
// the result output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "polynomial_add_multiply_unit_assert.svh"

module pam_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_wdata,
    input  wire pam_pkg::ops_t                        ops,
    output      pam_pkg::sts_t                        sts,
    input  wire logic                                 in_valid,
    input  wire logic [pam_pkg::CMD_W-1:0]            in_cmd,
    input  wire logic signed [pam_pkg::IN_COEF_W-1:0] in_coef,
    input  wire logic                                 out_ready,
    output      logic                                 out_valid,
    output      logic signed [pam_pkg::RES_W-1:0]     out_coef,
    output      logic [pam_pkg::EXP_W-1:0]            out_exp,
    output      logic                                 out_last
);
    import pam_pkg::*;

    logic                     mode_reg;
    logic [CNT_W-1:0]         a_cnt_reg;
    logic [CNT_W-1:0]         b_cnt_reg;
    logic [EXP_W-1:0]         i_reg;
    logic [ADDR_W-1:0]        j_reg;
    logic [ADDR_W-1:0]        jhi_reg;
    logic                     p1_valid_reg;
    logic                     p1_va_reg;
    logic                     p1_vb_reg;
    logic                     p2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RES_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [RES_W-1:0]  out_coef_reg;
    logic [EXP_W-1:0]         out_exp_reg;
    logic                     out_last_reg;

    logic signed [COEF_BITS-1:0] coef_in;
    logic                        a_we;
    logic                        b_we;
    logic [ADDR_W-1:0]           addr_b;
    logic [COEF_BITS-1:0]        ra;
    logic [COEF_BITS-1:0]        rb;
    logic signed [COEF_BITS-1:0] ra_s;
    logic signed [COEF_BITS-1:0] rb_s;
    logic signed [COEF_BITS:0]   sum_ab;
    logic [EXP_W:0]              aw;
    logic [EXP_W:0]              bw;
    logic [EXP_W:0]              iw;
    logic [EXP_W:0]              t_last;
    logic [EXP_W:0]              jlo_mul;
    logic [EXP_W:0]              jhi_mul;
    logic [ADDR_W-1:0]           term_jlo;
    logic [ADDR_W-1:0]           term_jhi;
    logic                        out_free;

    assign coef_in = COEF_BITS'(in_coef);
    assign a_we = ops.accept && (in_cmd == CMD_APPEND_FIRST)
                  && (a_cnt_reg < CNT_W'(MAX_TERMS));
    assign b_we = ops.accept && (in_cmd == CMD_APPEND_SECOND)
                  && (b_cnt_reg < CNT_W'(MAX_TERMS));

    // In multiply mode the second store is read at i - j; in add mode both
    // stores are read at the term index itself.
    assign addr_b = mode_reg ? ADDR_W'(i_reg - EXP_W'(j_reg)) : j_reg;

    pam_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TERMS)) u_first_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_cnt_reg[ADDR_W-1:0]),
        .wdata (coef_in),
        .re    (ops.issue),
        .raddr (j_reg),
        .rdata (ra)
    );

    pam_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TERMS)) u_second_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_cnt_reg[ADDR_W-1:0]),
        .wdata (coef_in),
        .re    (ops.issue),
        .raddr (addr_b),
        .rdata (rb)
    );

    assign ra_s = signed'(ra);
    assign rb_s = signed'(rb);
    assign sum_ab = (p1_va_reg ? (COEF_BITS+1)'(ra_s) : '0)
                  + (p1_vb_reg ? (COEF_BITS+1)'(rb_s) : '0);

    always_comb
    begin
        aw = (EXP_W+1)'(a_cnt_reg);
        bw = (EXP_W+1)'(b_cnt_reg);
        iw = (EXP_W+1)'(i_reg);

        if (mode_reg)
        begin
            t_last = aw + bw - (EXP_W+1)'(2);
        end
        else
        begin
            t_last = ((aw > bw) ? aw : bw) - (EXP_W+1)'(1);
        end

        // Products of term i pair first[j] with second[i - j] for every j
        // that keeps both indexes inside their polynomials.
        jlo_mul = (iw >= bw) ? (iw - bw + (EXP_W+1)'(1)) : '0;
        jhi_mul = (iw < aw) ? iw : (aw - (EXP_W+1)'(1));
        term_jlo = mode_reg ? ADDR_W'(jlo_mul) : ADDR_W'(i_reg);
        term_jhi = mode_reg ? ADDR_W'(jhi_mul) : ADDR_W'(i_reg);

        out_free = !out_valid_reg || out_ready;

        sts.in_valid    = in_valid;
        sts.not_compute = (in_cmd != CMD_COMPUTE);
        sts.empty       = mode_reg ? ((a_cnt_reg == '0) || (b_cnt_reg == '0))
                                   : ((a_cnt_reg == '0) && (b_cnt_reg == '0));
        sts.more_j      = (j_reg != jhi_reg);
        sts.last_term   = (iw == t_last);
        sts.pipe_empty  = !p1_valid_reg && !p2_valid_reg;
        sts.out_free    = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b1;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end

            if (ops.accept && (in_cmd == CMD_CLEAR))
            begin
                a_cnt_reg <= '0;
                b_cnt_reg <= '0;
            end
            else
            begin
                if (a_we)
                begin
                    a_cnt_reg <= a_cnt_reg + CNT_W'(1);
                end
                if (b_we)
                begin
                    b_cnt_reg <= b_cnt_reg + CNT_W'(1);
                end
            end

            p1_valid_reg <= ops.issue;
            p2_valid_reg <= p1_valid_reg;

            if (ops.emit_acc || ops.emit_zero)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ops.init_i)
        begin
            i_reg <= '0;
        end
        else if (ops.emit_acc)
        begin
            i_reg <= i_reg + EXP_W'(1);
        end

        if (ops.init_term)
        begin
            j_reg   <= term_jlo;
            jhi_reg <= term_jhi;
        end
        else if (ops.issue)
        begin
            j_reg <= j_reg + ADDR_W'(1);
        end

        if (ops.issue)
        begin
            p1_va_reg <= mode_reg || (iw < aw);
            p1_vb_reg <= mode_reg || (iw < bw);
        end

        if (p1_valid_reg)
        begin
            prod_reg <= mode_reg ? (ra_s * rb_s) : PROD_W'(sum_ab);
        end

        if (ops.init_term)
        begin
            acc_reg <= '0;
        end
        else if (p2_valid_reg)
        begin
            acc_reg <= acc_reg + RES_W'(prod_reg);
        end

        if (ops.emit_acc)
        begin
            out_coef_reg <= acc_reg;
            out_exp_reg  <= i_reg;
            out_last_reg <= sts.last_term;
        end
        else if (ops.emit_zero)
        begin
            out_coef_reg <= '0;
            out_exp_reg  <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_coef  = out_coef_reg;
    assign out_exp   = out_exp_reg;
    assign out_last  = out_last_reg;

    `PAM_ASSERT_ALWAYS(count_in_range, (a_cnt_reg <= CNT_W'(MAX_TERMS)) && (b_cnt_reg <= CNT_W'(MAX_TERMS)), "store count beyond depth")
    `PAM_ASSERT_IMPL(emit_after_drain, ops.emit_acc, !p1_valid_reg && !p2_valid_reg, "term emitted before accumulation finished")
    `PAM_ASSERT_NEXT(issue_feeds_pipe, ops.issue, p1_valid_reg, "issued read did not enter the pipeline")
    `PAM_ASSERT_IMPL(issue_within_range, ops.issue, j_reg <= jhi_reg, "product index beyond its upper bound")

endmodule

`default_nettype wire

[sv/polynomial_add_multiply_unit.sv]
// ---------------------------------------------------------------------------
// polynomial_add_multiply_unit
// Two coefficient stores with a microcoded add / convolution engine.
// ---------------------------------------------------------------------------
// Usage:
// Each word on the command channel either appends a signed coefficient to
// the first or second polynomial (next higher power), clears both, or asks
// for a result. Appends past the store depth are dropped. Append and clear
// words are taken without leaving the idle step. A compute word emits one
// result word per term on the result channel, lowest power first, with the
// highest term marked last; an empty result is a single zero term marked
// last. cfg_we/cfg_wdata select addition (0) or multiplication (1) and are
// to be written while idle; the block itself does not enforce this.
// Sequence: the sequencer starts a result in its start and term steps, then
// per term issues one product read from the stores per cycle, waits in the
// drain step until the pipeline is empty and emits the term. The store
// read ports feed one multiply-accumulate per cycle.
// The result register holds a term until taken; a stalled receiver holds
// the sequencer at the emit steps only. Reset empties both polynomials and
// selects multiply mode; no clearing pass follows reset.
// ---------------------------------------------------------------------------
`default_nettype none

module polynomial_add_multiply_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    pam_in_if.sink    command,
    pam_out_if.source result
);
    import pam_pkg::*;

    ops_t ops;
    sts_t sts;
    logic ready;

    pam_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ops   (ops),
        .ready (ready)
    );

    pam_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ops       (ops),
        .sts       (sts),
        .in_valid  (command.valid),
        .in_cmd    (command.cmd),
        .in_coef   (command.coefficient),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_coef  (result.result_coefficient),
        .out_exp   (result.exponent),
        .out_last  (result.last)
    );

    assign command.ready = ready;

endmodule

`default_nettype wire

[verif/polynomial_add_multiply_checker.sv]
// ---------------------------------------------------------------------------
// polynomial_add_multiply_checker
// Watches the command and result channels of the polynomial add / multiply
// unit. It keeps its own copy of both polynomials and the mode. From these it
// predicts every result term and compares each term taken from the block with
// the oldest term still owed.
// ---------------------------------------------------------------------------
`default_nettype none

package pam_mode_pkg;

    typedef enum logic {
        MODE_ADD = 1'b0,
        MODE_MUL = 1'b1
    } mode_t;

endpackage

module polynomial_add_multiply_checker
    import pam_pkg::*;
    import pam_mode_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    pam_in_if    in_ch,
    pam_out_if   out_ch,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic signed [RES_W-1:0] coef;
        logic [EXP_W-1:0]        expo;
        logic                    last;
    } term_t;

    term_t                       owed_terms[$];
    logic signed [COEF_BITS-1:0] first_poly [MAX_TERMS];
    logic signed [COEF_BITS-1:0] second_poly [MAX_TERMS];
    int                          first_len;
    int                          second_len;
    mode_t                       mode_sel;

    function automatic term_t make_term(input longint value, input int power, input bit top);
        term_t t;
        t.coef = RES_W'(value);
        t.expo = EXP_W'(power);
        t.last = top;
        return t;
    endfunction

    // Term-wise sum in add mode, full convolution in multiply mode.
    task automatic push_result_terms();
        int     n_terms;
        longint acc;
        if (mode_sel == MODE_ADD)
            n_terms = (first_len > second_len) ? first_len : second_len;
        else
            n_terms = (first_len == 0 || second_len == 0) ? 0 : first_len + second_len - 1;
        if (n_terms == 0)
            owed_terms.push_back(make_term(0, 0, 1'b1));
        for (int i = 0; i < n_terms; i++)
        begin
            acc = 0;
            if (mode_sel == MODE_ADD)
            begin
                if (i < first_len)
                    acc += longint'(first_poly[ADDR_W'(i)]);
                if (i < second_len)
                    acc += longint'(second_poly[ADDR_W'(i)]);
            end
            else
            begin
                for (int j = 0; j < first_len; j++)
                begin
                    if (i - j >= 0 && i - j < second_len)
                        acc += longint'(first_poly[ADDR_W'(j)])
                               * longint'(second_poly[ADDR_W'(i - j)]);
                end
            end
            owed_terms.push_back(make_term(acc, i, i == n_terms - 1));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        term_t got;
        term_t want;
        if (!rst_n)
        begin
            owed_terms.delete();
            first_len  = 0;
            second_len = 0;
            mode_sel   = MODE_MUL;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.coef = out_ch.result_coefficient;
                got.expo = out_ch.exponent;
                got.last = out_ch.last;
                if (owed_terms.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected term: expected none, got coef %0d exp %0d last %0b",
                             $time, got.coef, got.expo, got.last);
                end
                else
                begin
                    want = owed_terms.pop_front();
                    if (got.coef !== want.coef || got.expo !== want.expo ||
                        got.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: term mismatch: expected coef %0d exp %0d last %0b, got coef %0d exp %0d last %0b",
                                 $time, want.coef, want.expo, want.last,
                                 got.coef, got.expo, got.last);
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                case (cmd_t'(in_ch.cmd))
                    CMD_APPEND_FIRST:
                        if (first_len < MAX_TERMS)
                        begin
                            first_poly[ADDR_W'(first_len)] = in_ch.coefficient[COEF_BITS-1:0];
                            first_len++;
                        end
                    CMD_APPEND_SECOND:
                        if (second_len < MAX_TERMS)
                        begin
                            second_poly[ADDR_W'(second_len)] = in_ch.coefficient[COEF_BITS-1:0];
                            second_len++;
                        end
                    CMD_COMPUTE:
                        push_result_terms();
                    CMD_CLEAR:
                    begin
                        first_len  = 0;
                        second_len = 0;
                    end
                endcase
            end

            if (cfg_we)
                mode_sel = mode_t'(cfg_wdata);
            pending = owed_terms.size();
        end
    end

endmodule

`default_nettype wire

[verif/polynomial_add_multiply_unit_tb.sv]
// ---------------------------------------------------------------------------
// polynomial_add_multiply_unit_tb
// Drives command words into the polynomial add / multiply unit with random
// gaps and stalls the result channel at random. A directed opening covers
// empty results, extreme coefficients and both modes; random sequences of
// appends and computes follow, with full stores and stray words mixed in.
// The checker beside the block predicts and compares every term.
// ---------------------------------------------------------------------------
`default_nettype none

module polynomial_add_multiply_unit_tb;
    import pam_pkg::*;
    import pam_mode_pkg::*;

    localparam int WORD_BUDGET = 150;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_count;
    int   pending;
    int   words_sent;
    bit   calm;

    pam_in_if  in_ch ();
    pam_out_if out_ch ();

    polynomial_add_multiply_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .command   (in_ch),
        .result    (out_ch)
    );

    polynomial_add_multiply_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: a fresh stall before each word, none in calm stretches.
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    function automatic logic [IN_COEF_W-1:0] pick_coef();
        logic [IN_COEF_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'hFFFF;
            3:       v = 16'h0000;
            default: v = IN_COEF_W'($urandom);
        endcase
        return v;
    endfunction

    // Valid stays high across back-to-back words.
    task automatic send_word(input cmd_t op, input logic [IN_COEF_W-1:0] value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= op;
        in_ch.coefficient <= value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    // The extra edge lets the checker book the last word before pending is read.
    task automatic drain_results(input int settle);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_mode(input mode_t m);
        drain_results(8);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int seq;
        int na;
        int nb;
        bit big;
        words_sent = 0;
        calm       = 1'b0;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= MODE_MUL;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_CLEAR;
        in_ch.coefficient <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Multiply mode out of reset: empty operands, then extreme products.
        send_word(CMD_COMPUTE, 16'h0000);
        send_word(CMD_APPEND_FIRST, 16'h7FFF);
        send_word(CMD_APPEND_FIRST, 16'h8000);
        send_word(CMD_COMPUTE, 16'h0000);
        send_word(CMD_APPEND_SECOND, 16'h8000);
        send_word(CMD_APPEND_SECOND, 16'h7FFF);
        send_word(CMD_COMPUTE, 16'hFFFF);
        send_word(CMD_CLEAR, 16'hFFFF);
        send_word(CMD_COMPUTE, 16'h5A5A);

        set_mode(MODE_ADD);
        send_word(CMD_APPEND_SECOND, 16'h8000);
        send_word(CMD_COMPUTE, 16'hA5A5);
        send_word(CMD_APPEND_FIRST, 16'h8000);
        send_word(CMD_APPEND_FIRST, 16'h7FFF);
        send_word(CMD_COMPUTE, 16'h0000);
        send_word(CMD_CLEAR, 16'h0000);
        send_word(CMD_COMPUTE, 16'h0000);
        send_word(CMD_APPEND_FIRST, 16'h0001);
        send_word(CMD_COMPUTE, 16'h0000);

        // Two large sequences overfill the stores: a full-size convolution
        // and a full-length sum. The rest use small polynomials.
        seq = 0;
        while (words_sent < WORD_BUDGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            big  = (seq == 1 || seq == 2);
            if (seq == 1)
                set_mode(MODE_MUL);
            else if (seq == 2)
                set_mode(MODE_ADD);
            else if ($urandom_range(0, 2) == 0)
                set_mode(mode_t'($urandom_range(0, 1)));

            if (seq == 1)
            begin
                na = 34;
                nb = 33;
            end
            else if (seq == 2)
            begin
                na = $urandom_range(28, 34);
                nb = 34;
            end
            else
            begin
                na = $urandom_range(0, 6);
                nb = $urandom_range(0, 6);
            end

            if (big || $urandom_range(0, 3) != 0)
                send_word(CMD_CLEAR, IN_COEF_W'($urandom));
            while (na + nb > 0)
            begin
                if (!big && $urandom_range(0, 7) == 0)
                    send_word(cmd_t'($urandom_range(0, 3)), IN_COEF_W'($urandom));
                else if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0))
                begin
                    send_word(CMD_APPEND_FIRST, pick_coef());
                    na--;
                end
                else
                begin
                    send_word(CMD_APPEND_SECOND, pick_coef());
                    nb--;
                end
            end
            send_word(CMD_COMPUTE, IN_COEF_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                send_word(CMD_COMPUTE, IN_COEF_W'($urandom));
            seq++;
        end

        calm = 1'b0;
        drain_results(40);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
